### rtl/core/edfq_pkg.sv
// Shared types and constants of the EDF quantum dispatcher.
// No dependencies; used by the interfaces and every module of the block.
`timescale 1ns / 1ps

package edfq_pkg;

    // field widths
    localparam int unsigned BURST_W    = 16;
    localparam int unsigned DL_W       = 32;
    localparam int unsigned ID_W       = 16;
    localparam int unsigned STAT_W     = 2;
    localparam int unsigned Q_W        = 16;
    localparam int unsigned TIME_W     = 32;

    // input kind codes
    localparam logic KIND_ADD      = 1'b0;
    localparam logic KIND_DISPATCH = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_ADDED      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL       = 2'd1;
    localparam logic [STAT_W-1:0] ST_DISPATCHED = 2'd2;
    localparam logic [STAT_W-1:0] ST_IDLE       = 2'd3;

    // quantum after reset
    localparam logic [Q_W-1:0] QUANTUM_RESET = 16'd10;

    // one task slot as held in the slot memory
    typedef struct packed {
        logic [DL_W-1:0]    dl;
        logic [BURST_W-1:0] rem;
        logic [ID_W-1:0]    id;
    } t_slot;

    // controller to datapath
    typedef struct packed {
        logic start;   // latch the word, restart the slot scan
        logic scan;    // step the slot scan
        logic slice;   // work out the granted slice
        logic commit;  // update the table and load the result register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;  // last slot evaluated this cycle
        logic out_busy;   // result register full and not taken this cycle
    } t_dp_stat;

endpackage

### rtl/core/edfq_task_if.sv
// Input channel of the EDF quantum dispatcher: valid/ready and the task word.
// Depends on edfq_pkg.
`timescale 1ns / 1ps

interface edfq_task_if import edfq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [BURST_W-1:0] burst;
    logic [DL_W-1:0]    deadline;

    modport source (output valid, kind, burst, deadline, input ready);
    modport sink   (input valid, kind, burst, deadline, output ready);
endinterface

### rtl/core/edfq_res_if.sv
// Result channel of the EDF quantum dispatcher: valid/ready and the result word.
// Depends on edfq_pkg.
`timescale 1ns / 1ps

interface edfq_res_if import edfq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [ID_W-1:0]    task_id;
    logic [BURST_W-1:0] slice_length;
    logic               finished;
    logic               deadline_missed;
    logic [TIME_W-1:0]  time_now;

    modport source (output valid, status, task_id, slice_length, finished,
                    deadline_missed, time_now, input ready);
    modport sink   (input valid, status, task_id, slice_length, finished,
                    deadline_missed, time_now, output ready);
endinterface

### rtl/core/edf_quantum_dispatcher.sv
// Earliest-deadline-first dispatcher with a fixed time quantum.
// Usage:
//   i_task carries one word per item: kind (add or dispatch), burst, deadline.
//   o_res returns exactly one result word per item, in order.
//   i_cfg_wr_en / i_cfg_wr_data write the quantum; write only while idle.
// Item flow:
//   Every item scans all MAX_TASKS slots through the slot memory read port,
//   one slot per cycle through a registered read, then works out the slice
//   and commits; commit waits while the result register is full and not taken.
//   A new word is taken only in idle, once the previous item has committed.
// Reset (synchronous, i_rst_n low): all slots free, time and id counter
//   zero, quantum 10. Slot contents are not cleared; only valid slots are used.
// Stalls: the result sits in an output register, so a new word is taken while
//   it waits; a second result waits in commit until the first is taken.
// Depends on edfq_pkg, edfq_task_if, edfq_res_if, edfq_ctrl and edfq_dp.
`timescale 1ns / 1ps

module edf_quantum_dispatcher import edfq_pkg::*; #(
    parameter int unsigned MAX_TASKS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  logic [Q_W-1:0] i_cfg_wr_data,
    edfq_task_if.sink      i_task,
    edfq_res_if.source     o_res
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer
    edfq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .i_task  (i_task)
    );

    // slot table and arithmetic
    edfq_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_task        (i_task),
        .o_res         (o_res)
    );

endmodule

### rtl/core/edfq_ctrl.sv
// Controller of the EDF quantum dispatcher: sequences scan, slice and commit.
// Depends on edfq_pkg and edfq_task_if.
`timescale 1ns / 1ps

module edfq_ctrl import edfq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    edfq_task_if.sink i_task
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SLICE,
        S_COMMIT
    } t_state;

    t_state r_state;
    logic   accept;

    // take a word only between items
    assign i_task.ready = (r_state == S_IDLE);
    assign accept       = i_task.valid && (r_state == S_IDLE);

    // command decode
    always_comb begin
        o_cmd        = '0;
        o_cmd.start  = accept;
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.slice  = (r_state == S_SLICE);
        o_cmd.commit = (r_state == S_COMMIT) && !i_stat.out_busy;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (i_stat.scan_done) r_state <= S_SLICE;
                end
                S_SLICE: begin
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (!i_stat.out_busy) r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/core/edfq_dp.sv
// Datapath of the EDF quantum dispatcher: slot memory, valid bits, scan
// pipeline, time and id counters, quantum register and result register.
// Depends on edfq_pkg, edfq_task_if and edfq_res_if.
`timescale 1ns / 1ps

module edfq_dp import edfq_pkg::*; #(
    parameter int unsigned MAX_TASKS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_dp_cmd        i_cmd,
    output t_dp_stat       o_stat,
    input  logic           i_cfg_wr_en,
    input  logic [Q_W-1:0] i_cfg_wr_data,
    edfq_task_if.sink      i_task,
    edfq_res_if.source     o_res
);

    localparam int unsigned IW = $clog2(MAX_TASKS);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TASKS - 1);

    // slot memory and valid bits
    t_slot              r_mem [MAX_TASKS];
    t_slot              r_rd;
    logic [MAX_TASKS-1:0] r_valid;

    // latched input word
    logic               r_kind;
    logic [BURST_W-1:0] r_burst;
    logic [DL_W-1:0]    r_deadline;

    // scan: issue stage and data stage
    logic [IW-1:0]      r_iss_idx;
    logic               r_iss_on;
    logic               r_p_vld;
    logic [IW-1:0]      r_p_idx;
    logic               r_p_sv;

    // scan result
    logic               r_found;
    logic [IW-1:0]      r_pick;
    t_slot              r_best;
    logic [BURST_W-1:0] r_slice;

    // global state
    logic [TIME_W-1:0]  r_time;
    logic [ID_W-1:0]    r_id_ctr;
    logic [Q_W-1:0]     r_quantum;

    // result register
    logic               r_out_vld;
    logic [STAT_W-1:0]  r_out_status;
    logic [ID_W-1:0]    r_out_id;
    logic [BURST_W-1:0] r_out_slice;
    logic               r_out_fin;
    logic               r_out_miss;
    logic [TIME_W-1:0]  r_out_time;

    // commit arithmetic
    logic [ID_W-1:0]    n_id;
    logic [BURST_W-1:0] n_rem;
    logic [TIME_W-1:0]  n_time;
    logic               n_fin;
    logic               n_miss;
    logic               issue;
    logic               better;
    logic               is_add;
    logic               mem_we;
    t_slot              mem_wdata;

    assign issue  = i_cmd.scan && r_iss_on;
    assign is_add = (r_kind == KIND_ADD);

    // candidate in the data stage beats the current best
    always_comb begin
        if (is_add) begin
            better = !r_p_sv && !r_found;
        end else begin
            better = r_p_sv && (!r_found || (r_rd.dl < r_best.dl));
        end
    end

    always_comb begin
        n_id   = r_id_ctr + ID_W'(1);
        n_rem  = r_best.rem - r_slice;
        n_time = r_time + TIME_W'(r_slice);
        n_fin  = (n_rem == '0);
        n_miss = !n_fin && (n_time > r_best.dl);
    end

    // slot write on commit: new task, or remaining time of an unfinished one
    always_comb begin
        mem_we = i_cmd.commit && r_found && (is_add || !n_fin);
        if (is_add) begin
            mem_wdata = '{dl: r_deadline, rem: r_burst, id: n_id};
        end else begin
            mem_wdata = '{dl: r_best.dl, rem: n_rem, id: r_best.id};
        end
    end

    assign o_stat.scan_done = r_p_vld && (r_p_idx == LAST_IDX);
    assign o_stat.out_busy  = r_out_vld && !o_res.ready;

    // slot memory: one read port for the scan, one write port for commit
    always_ff @(posedge i_clk) begin
        if (issue) r_rd <= r_mem[r_iss_idx];
        if (mem_we) r_mem[r_pick] <= mem_wdata;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_iss_on  <= 1'b0;
            r_p_vld   <= 1'b0;
            r_found   <= 1'b0;
            r_time    <= '0;
            r_id_ctr  <= '0;
            r_quantum <= QUANTUM_RESET;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_quantum <= i_cfg_wr_data;

            // scan issue
            r_p_vld <= issue;
            if (i_cmd.start) begin
                r_iss_on <= 1'b1;
            end else if (issue && (r_iss_idx == LAST_IDX)) begin
                r_iss_on <= 1'b0;
            end

            // scan evaluate
            if (i_cmd.start) begin
                r_found <= 1'b0;
            end else if (r_p_vld && better) begin
                r_found <= 1'b1;
            end

            // commit
            if (i_cmd.commit && r_found) begin
                if (is_add) begin
                    r_id_ctr         <= n_id;
                    r_valid[r_pick]  <= 1'b1;
                end else begin
                    r_time <= n_time;
                    if (n_fin) r_valid[r_pick] <= 1'b0;
                end
            end

            // result register
            if (i_cmd.commit) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_kind     <= i_task.kind;
            r_burst    <= i_task.burst;
            r_deadline <= i_task.deadline;
            r_iss_idx  <= '0;
        end else if (issue && (r_iss_idx != LAST_IDX)) begin
            r_iss_idx <= r_iss_idx + IW'(1);
        end

        if (issue) begin
            r_p_idx <= r_iss_idx;
            r_p_sv  <= r_valid[r_iss_idx];
        end

        if (r_p_vld && better) begin
            r_pick <= r_p_idx;
            r_best <= r_rd;
        end

        if (i_cmd.slice) begin
            r_slice <= (r_best.rem < r_quantum) ? r_best.rem : r_quantum;
        end

        if (i_cmd.commit) begin
            r_out_id    <= '0;
            r_out_slice <= '0;
            r_out_fin   <= 1'b0;
            r_out_miss  <= 1'b0;
            r_out_time  <= r_time;
            if (is_add) begin
                if (r_found) begin
                    r_out_status <= ST_ADDED;
                    r_out_id     <= n_id;
                end else begin
                    r_out_status <= ST_FULL;
                end
            end else begin
                if (r_found) begin
                    r_out_status <= ST_DISPATCHED;
                    r_out_id     <= r_best.id;
                    r_out_slice  <= r_slice;
                    r_out_fin    <= n_fin;
                    r_out_miss   <= n_miss;
                    r_out_time   <= n_time;
                end else begin
                    r_out_status <= ST_IDLE;
                end
            end
        end
    end

    assign o_res.valid           = r_out_vld;
    assign o_res.status          = r_out_status;
    assign o_res.task_id         = r_out_id;
    assign o_res.slice_length    = r_out_slice;
    assign o_res.finished        = r_out_fin;
    assign o_res.deadline_missed = r_out_miss;
    assign o_res.time_now        = r_out_time;

endmodule

### sim/tb_edf_quantum_dispatcher.sv
// Self-checking testbench for edf_quantum_dispatcher: directed and random task words,
// a scoreboard class that predicts every result, random gaps on the input and back-pressure on results.
// Depends on edfq_pkg, edfq_task_if, edfq_res_if and the dispatcher RTL.
`timescale 1ns / 1ps

module tb_edf_quantum_dispatcher;
    import edfq_pkg::*;

    localparam int unsigned SLOTS        = 16;
    localparam int unsigned DRAIN_CYCLES = SLOTS + 8;
    localparam int unsigned HOLD_AT      = 300;   // results seen before the long stall
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned CALM_FROM    = 500;   // window with no idling on either side
    localparam int unsigned CALM_TO      = 600;
    localparam int unsigned PHASES       = 6;
    localparam int unsigned PHASE_WORDS  = 130;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [ID_W-1:0]    task_id;
        logic [BURST_W-1:0] slice_length;
        logic               finished;
        logic               deadline_missed;
        logic [TIME_W-1:0]  time_now;
    } result_t;

    // Shadow of the slot table; predicts one result per accepted word
    class dispatch_scoreboard;
        bit                 slot_used [SLOTS];
        logic [DL_W-1:0]    slot_dl   [SLOTS];
        logic [BURST_W-1:0] slot_rem  [SLOTS];
        logic [ID_W-1:0]    slot_id   [SLOTS];
        logic [TIME_W-1:0]  sched_time;
        logic [ID_W-1:0]    last_id;
        logic [Q_W-1:0]     quantum;
        result_t            expected_q [$];
        int unsigned        mismatches;

        function new();
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            sched_time = '0;
            last_id    = '0;
            quantum    = QUANTUM_RESET;
            mismatches = 0;
        endfunction

        function void set_quantum(logic [Q_W-1:0] q);
            quantum = q;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function void note_word(logic kind, logic [BURST_W-1:0] burst, logic [DL_W-1:0] dl);
            result_t            r;
            int                 pick;
            logic [BURST_W-1:0] slice;
            pick = -1;
            r    = '0;
            if (kind == KIND_ADD) begin
                // lowest free slot takes the next id
                for (int i = 0; i < SLOTS; i++) begin
                    if (!slot_used[i] && pick < 0) pick = i;
                end
                if (pick < 0) begin
                    r.status = ST_FULL;
                end else begin
                    last_id         = last_id + 1'b1;
                    slot_used[pick] = 1'b1;
                    slot_rem[pick]  = burst;
                    slot_dl[pick]   = dl;
                    slot_id[pick]   = last_id;
                    r.status        = ST_ADDED;
                    r.task_id       = last_id;
                end
            end else begin
                // earliest deadline, lowest slot on a tie
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_used[i] && (pick < 0 || slot_dl[i] < slot_dl[pick])) pick = i;
                end
                if (pick < 0) begin
                    r.status = ST_IDLE;
                end else begin
                    slice          = (slot_rem[pick] < quantum) ? slot_rem[pick] : quantum;
                    slot_rem[pick] = slot_rem[pick] - slice;
                    sched_time     = sched_time + TIME_W'(slice);
                    r.status       = ST_DISPATCHED;
                    r.task_id      = slot_id[pick];
                    r.slice_length = slice;
                    if (slot_rem[pick] == '0) begin
                        slot_used[pick] = 1'b0;
                        r.finished      = 1'b1;
                    end else if (sched_time > slot_dl[pick]) begin
                        r.deadline_missed = 1'b1;
                    end
                end
            end
            r.time_now = sched_time;
            expected_q.push_back(r);
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, field, want, got);
        endfunction

        function void check_word(result_t got);
            result_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                $display("%0t ns: result with none expected, expected nothing actual %0h",
                         $time, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
                report("status", 32'(want.status), 32'(got.status));
            if (got.task_id !== want.task_id)
                report("task_id", 32'(want.task_id), 32'(got.task_id));
            if (got.slice_length !== want.slice_length)
                report("slice_length", 32'(want.slice_length), 32'(got.slice_length));
            if (got.finished !== want.finished)
                report("finished", 32'(want.finished), 32'(got.finished));
            if (got.deadline_missed !== want.deadline_missed)
                report("deadline_missed", 32'(want.deadline_missed), 32'(got.deadline_missed));
            if (got.time_now !== want.time_now)
                report("time_now", want.time_now, got.time_now);
        endfunction
    endclass

    logic           i_clk;
    logic           i_rst_n;
    logic           cfg_wr_en;
    logic [Q_W-1:0] cfg_wr_data;
    int unsigned    words_sent;
    int unsigned    results_seen;

    edfq_task_if word_ch ();
    edfq_res_if  res_ch ();

    dispatch_scoreboard sb = new();

    edf_quantum_dispatcher #(
        .MAX_TASKS(SLOTS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_task       (word_ch),
        .o_res        (res_ch)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("edf_quantum_dispatcher verification failed");
        $finish;
    end

    // result side: random stalls, one long hold-off, a calm window
    initial begin
        int unsigned hold_left;
        bit          held;
        result_t     got;
        hold_left    = 0;
        held         = 1'b0;
        results_seen = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                res_ch.ready = 1'b0;
                hold_left--;
            end else if (results_seen >= CALM_FROM && results_seen < CALM_TO) begin
                res_ch.ready = 1'b1;
            end else begin
                res_ch.ready = ($urandom_range(99) >= 13);
            end
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                got.status          = res_ch.status;
                got.task_id         = res_ch.task_id;
                got.slice_length    = res_ch.slice_length;
                got.finished        = res_ch.finished;
                got.deadline_missed = res_ch.deadline_missed;
                got.time_now        = res_ch.time_now;
                sb.check_word(got);
                results_seen++;
            end
        end
    end

    // offer one word, hold it until taken, then maybe idle before the next
    task automatic send_word(input logic kind, input logic [BURST_W-1:0] burst,
                             input logic [DL_W-1:0] dl);
        int unsigned gap;
        word_ch.kind     = kind;
        word_ch.burst    = burst;
        word_ch.deadline = dl;
        word_ch.valid    = 1'b1;
        do @(posedge i_clk); while (!word_ch.ready);
        sb.note_word(kind, burst, dl);
        words_sent++;
        @(negedge i_clk);
        gap = 0;
        if ((words_sent < CALM_FROM || words_sent >= CALM_TO) && $urandom_range(99) < 13)
            gap = $urandom_range(1, 4);
        if (gap != 0) begin
            word_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // quantum write once every result is back
    task automatic write_quantum(input logic [Q_W-1:0] q);
        word_ch.valid = 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
        cfg_wr_data = q;
        cfg_wr_en   = 1'b1;
        @(posedge i_clk);
        sb.set_quantum(q);
        @(negedge i_clk);
        cfg_wr_en = 1'b0;
    endtask

    // stimulus
    initial begin
        logic               kind;
        logic [BURST_W-1:0] burst;
        logic [DL_W-1:0]    dl;
        logic [Q_W-1:0]     q;
        bit                 add_heavy;
        int unsigned        r;

        words_sent       = 0;
        i_rst_n          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        word_ch.valid    = 1'b0;
        word_ch.kind     = KIND_ADD;
        word_ch.burst    = '0;
        word_ch.deadline = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: empty dispatch, zero burst, extremes, deadline tie, miss, full table
        send_word(KIND_DISPATCH, '0, '0);
        send_word(KIND_ADD, 16'd0, 32'd0);
        send_word(KIND_ADD, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(KIND_ADD, 16'd25, 32'd5);
        send_word(KIND_ADD, 16'd3, 32'd5);
        repeat (5) send_word(KIND_DISPATCH, 16'hFFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < SLOTS - 1; i++)
            send_word(KIND_ADD, BURST_W'(i + 1), DL_W'(1000 - 7 * i));
        send_word(KIND_ADD, 16'd1, 32'd1);

        // random phases, each under its own quantum
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       q = 16'd1;
                1:       q = 16'hFFFF;
                2:       q = QUANTUM_RESET;
                3:       q = Q_W'($urandom_range(2, 40));
                default: q = Q_W'($urandom_range(1, 65535));
            endcase
            write_quantum(q);
            add_heavy = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // swing between filling and draining the table
                if (n % 20 == 0) add_heavy = $urandom_range(1);
                kind = ($urandom_range(99) < (add_heavy ? 75 : 25)) ? KIND_ADD : KIND_DISPATCH;
                r = $urandom_range(99);
                if (r < 10)      burst = '0;
                else if (r < 20) burst = '1;
                else if (r < 30) burst = BURST_W'($urandom);
                else             burst = BURST_W'($urandom_range(1, 40));
                r = $urandom_range(99);
                if (r < 10)      dl = $urandom;
                else if (r < 15) dl = '1;
                else if (r < 20) dl = '0;
                else if (r < 45) dl = sb.sched_time + DL_W'($urandom_range(0, 15) * 8);
                else if (r < 60) dl = sb.sched_time - DL_W'($urandom_range(1, 50));
                else             dl = sb.sched_time + DL_W'($urandom_range(0, 400));
                send_word(kind, burst, dl);
            end
        end

        // drain and decide
        word_ch.valid = 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("edf_quantum_dispatcher verification clean");
        end else begin
            $display("edf_quantum_dispatcher verification failed");
        end
        $finish;
    end

endmodule
